// File: src/fpa_pkg.sv
package fpa_pkg;

  localparam int FracBitsDefault = 8;
  localparam int DataW = 32;
  localparam int DivStages = DataW + FracBitsDefault;

  typedef enum logic [3:0] {
    FN_ADD     = 4'd0,
    FN_SUB     = 4'd1,
    FN_MUL     = 4'd2,
    FN_DIV     = 4'd3,
    FN_GT      = 4'd4,
    FN_LT      = 4'd5,
    FN_GE      = 4'd6,
    FN_LE      = 4'd7,
    FN_EQ      = 4'd8,
    FN_NE      = 4'd9,
    FN_MIN     = 4'd10,
    FN_MAX     = 4'd11,
    FN_INC     = 4'd12,
    FN_DEC     = 4'd13,
    FN_TOINT   = 4'd14,
    FN_FROMINT = 4'd15
  } func_t;

  typedef enum logic [1:0] {
    CL_SIMPLE = 2'd0,
    CL_MUL    = 2'd1,
    CL_DIV    = 2'd2
  } cls_t;

  typedef struct packed {
    func_t              func;
    cls_t               cls;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } op_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               flag;
    logic               dz;
  } res_t;

endpackage

// File: src/fpa_front.sv
module fpa_front
  import fpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               op_vld,
  output op_t                op,
  input  logic               op_rdy
);

  // two-entry queue to the back end
  op_t        q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  op_t        cls_op;
  logic       push, pop;

  always_comb begin
    cls_op.func = func_t'(in_func);
    cls_op.a    = in_operand_a;
    cls_op.b    = in_operand_b;
    case (func_t'(in_func))
      FN_MUL:  cls_op.cls = CL_MUL;
      FN_DIV:  cls_op.cls = CL_DIV;
      default: cls_op.cls = CL_SIMPLE;
    endcase
  end

  assign in_full = (cnt_r == 2'd2);
  assign push    = in_push && !in_full;
  assign op_vld  = (cnt_r != 2'd0);
  assign op      = q_r[rp_r];
  assign pop     = op_vld && op_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls_op;
  end

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overfill");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("count did not rise");
  a_cnt_dn: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("count did not fall");
`endif

endmodule

// File: src/fpa_back.sv
module fpa_back
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic op_vld,
  input  op_t  op,
  output logic op_rdy,
  output logic res_vld,
  output res_t res,
  input  logic res_rdy
);

  localparam int NW = DataW + FRAC_BITS;
  localparam int NS = NW;
  localparam int LAT = NS + 1;

  // pipeline of LAT stages; every stage moves together when not stalled
  logic             adv;
  logic [LAT-1:0]   v_r;
  cls_t             cls_r [LAT];
  res_t             sres_r [LAT];
  // divider lanes
  logic [NW-1:0]    rem_r [NS+1];
  logic [NW-1:0]    quo_r [NS+1];
  logic [31:0]      den_r [NS+1];
  logic             neg_r [NS+1];
  logic             dz_r  [NS+1];
  // multiplier
  logic signed [63:0] prod_r;

  res_t simple;
  logic lt_ab, lt_ba, eqv;
  logic signed [63:0] sh;

  assign adv    = !v_r[LAT-1] || res_rdy;
  assign op_rdy = adv;
  assign res_vld = v_r[LAT-1];

  always_comb begin
    lt_ab = op.a < op.b;
    lt_ba = op.b < op.a;
    eqv   = op.a == op.b;
    simple = '0;
    case (op.func)
      FN_ADD:     simple.value = op.a + op.b;
      FN_SUB:     simple.value = op.a - op.b;
      FN_GT:      simple.flag = lt_ba;
      FN_LT:      simple.flag = lt_ab;
      FN_GE:      simple.flag = !lt_ab;
      FN_LE:      simple.flag = !lt_ba;
      FN_EQ:      simple.flag = eqv;
      FN_NE:      simple.flag = !eqv;
      FN_MIN:     simple.value = lt_ab ? op.a : op.b;
      FN_MAX:     simple.value = lt_ba ? op.a : op.b;
      FN_INC:     simple.value = op.a + 32'sd1;
      FN_DEC:     simple.value = op.a - 32'sd1;
      FN_TOINT:   simple.value = op.a >>> FRAC_BITS;
      FN_FROMINT: simple.value = op.a <<< FRAC_BITS;
      default:    simple = '0;
    endcase
  end

  assign sh = prod_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], op_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_r[0]  <= op.cls;
      sres_r[0] <= simple;
      prod_r    <= op.a * op.b;
      rem_r[0]  <= '0;
      quo_r[0]  <= {(op.a[31] ? -op.a : op.a), {FRAC_BITS{1'b0}}};
      den_r[0]  <= op.b[31] ? -op.b : op.b;
      neg_r[0]  <= op.a[31] ^ op.b[31];
      dz_r[0]   <= (op.b == '0);
      cls_r[1]  <= cls_r[0];
      sres_r[1] <= (cls_r[0] == CL_MUL) ? res_t'{value: sh[31:0], flag: 1'b0, dz: 1'b0}
                                        : sres_r[0];
      for (int i = 2; i < LAT; i++) begin
        cls_r[i]  <= cls_r[i-1];
        sres_r[i] <= sres_r[i-1];
      end
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [NW:0] trial;
    logic [NW-1:0] rsh;
    assign rsh   = {rem_r[s][NW-2:0], quo_r[s][NW-1]};
    assign trial = {1'b0, rsh} - {{(NW-31){1'b0}}, den_r[s]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= trial[NW] ? rsh : trial[NW-1:0];
        quo_r[s+1] <= {quo_r[s][NW-2:0], ~trial[NW]};
        den_r[s+1] <= den_r[s];
        neg_r[s+1] <= neg_r[s];
        dz_r[s+1]  <= dz_r[s];
      end
    end
  end

  logic [31:0] qv;
  assign qv = neg_r[NS] ? -quo_r[NS][31:0] : quo_r[NS][31:0];

  always_comb begin
    res = sres_r[LAT-1];
    if (cls_r[LAT-1] == CL_DIV) begin
      res.flag  = 1'b0;
      res.dz    = dz_r[NS];
      res.value = dz_r[NS] ? '0 : qv;
    end
  end

  logic unused;
  assign unused = ^rem_r[NS];

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && !res_rdy |=> res_vld)
    else $error("result dropped on stall");
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.dz |-> res.value == '0 && !res.flag)
    else $error("div by zero result not clean");
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && !res_rdy |-> !op_rdy)
    else $error("front not stalled");
`endif

endmodule

// File: src/fixed_point_alu_q24_8_top.sv
// channel | ports                                   | handshake
// input   | in_func, in_operand_a, in_operand_b     | in_push / in_full
// result  | out_value, out_flag, out_div_by_zero    | out_pop / out_empty
// One beat per cycle sustained unless out_pop stalls the pipeline; all operations
// share one pipeline that runs through the divider stages (one quotient bit per stage).
// A two-entry queue sits between decode and the execution pipeline.
// out_pop low with a result held stalls the whole pipeline; the queue then fills and raises in_full.
// Synchronous active-low reset empties queue and pipeline.
module fixed_point_alu_q24_8_top
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_value,
  output logic               out_flag,
  output logic               out_div_by_zero
);

  logic op_vld, op_rdy, res_vld;
  op_t  op;
  res_t res;

  fpa_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_func, .in_operand_a, .in_operand_b,
    .op_vld, .op, .op_rdy
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .op_vld, .op, .op_rdy, .res_vld, .res, .res_rdy(out_pop)
  );

  assign out_empty       = !res_vld;
  assign out_value       = res.value;
  assign out_flag        = res.flag;
  assign out_div_by_zero = res.dz;

endmodule

// File: tb/sv/tb_fixed_point_alu_q24_8_top.sv
`timescale 1ns / 100ps

module tb_fixed_point_alu_q24_8_top;
  import fpa_pkg::*;

  localparam int FRAC = FracBitsDefault;
  localparam int LATENCY = FRAC + 40;
  localparam int WATCHDOG = 5000;
  localparam int N_RANDOM = 1600;

  typedef struct packed {
    logic signed [31:0] value;
    logic               flag;
    logic               dz;
  } alu_res_t;

  typedef struct {
    func_t              fn;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               typed;
    alu_res_t           res;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [3:0]         in_func;
  logic signed [31:0] in_operand_a;
  logic signed [31:0] in_operand_b;
  logic               out_empty;
  logic               out_pop;
  logic signed [31:0] out_value;
  logic               out_flag;
  logic               out_div_by_zero;

  alu_res_t alu_expected_q[$];
  row_t     directed_rows[$];
  int       n_fail;
  int       n_sent;
  int       n_got;
  int       n_dz;
  int       idle_cycles;
  int       send_gap_pct;
  int       pop_stall_pct;
  bit       ops_seen[16];

  fixed_point_alu_q24_8_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_value      (out_value),
    .out_flag       (out_flag),
    .out_div_by_zero(out_div_by_zero)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic alu_res_t alu_compute(func_t fn, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_res_t           r;
    logic signed [63:0] prod;
    logic        [63:0] num;
    logic        [63:0] den;
    logic        [63:0] quo;
    r = '0;
    case (fn)
      FN_ADD: r.value = a + b;
      FN_SUB: r.value = a - b;
      FN_MUL: begin
        prod = 64'(a) * 64'(b);
        prod = prod >>> FRAC;
        r.value = prod[31:0];
      end
      FN_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = (a < 0) ? 64'(-64'(a)) : 64'(a);
          num = num << FRAC;
          den = (b < 0) ? 64'(-64'(b)) : 64'(b);
          quo = num / den;
          if (a[31] != b[31]) quo = -quo;
          r.value = quo[31:0];
        end
      end
      FN_GT: r.flag = a > b;
      FN_LT: r.flag = a < b;
      FN_GE: r.flag = a >= b;
      FN_LE: r.flag = a <= b;
      FN_EQ: r.flag = a == b;
      FN_NE: r.flag = a != b;
      FN_MIN: r.value = (a < b) ? a : b;
      FN_MAX: r.value = (a > b) ? a : b;
      FN_INC: r.value = a + 1;
      FN_DEC: r.value = a - 1;
      FN_TOINT: r.value = a >>> FRAC;
      default: r.value = a << FRAC;
    endcase
    return r;
  endfunction

  task automatic add_row(func_t fn, logic signed [31:0] a, logic signed [31:0] b,
                         logic typed = 1'b0, alu_res_t res = '0);
    row_t r;
    r.fn = fn;
    r.a = a;
    r.b = b;
    r.typed = typed;
    r.res = res;
    directed_rows.push_back(r);
  endtask

  task automatic send_beat(func_t fn, logic signed [31:0] a, logic signed [31:0] b,
                           logic typed, alu_res_t res);
    while ($urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_func <= fn;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    alu_expected_q.push_back(typed ? res : alu_compute(fn, a, b));
    ops_seen[fn] = 1'b1;
    n_sent++;
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom_range(2047) - 1024;
      1: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
      2: return {$urandom_range(1) ? 20'hFFFFF : 20'h00000, 12'($urandom)};
      3: return $urandom_range(1) ? 32'sh8000_0000 + $urandom_range(3)
                                  : 32'sh7FFF_FFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (alu_expected_q.size() == 0) begin
          $display("%0t: unexpected beat value=%0d flag=%0b dz=%0b", $time,
                   out_value, out_flag, out_div_by_zero);
          n_fail++;
        end else begin
          automatic alu_res_t e = alu_expected_q.pop_front();
          if (e.value !== out_value) begin
            $display("%0t: value expected %0d actual %0d", $time, e.value, out_value);
            n_fail++;
          end
          if (e.flag !== out_flag) begin
            $display("%0t: flag expected %0b actual %0b", $time, e.flag, out_flag);
            n_fail++;
          end
          if (e.dz !== out_div_by_zero) begin
            $display("%0t: div_by_zero expected %0b actual %0b", $time, e.dz,
                     out_div_by_zero);
            n_fail++;
          end
          if (e.dz) n_dz++;
        end
        n_got++;
      end
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: watchdog expired", $time);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int wait_n;
    int n_ops;
    func_t fn;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_func = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    out_pop = 1'b0;
    n_fail = 0;
    n_sent = 0;
    n_got = 0;
    n_dz = 0;
    idle_cycles = 0;
    send_gap_pct = 0;
    pop_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_row(FN_ADD, 32'sh7FFF_FFFF, 32'sd1, 1'b1, '{32'sh8000_0000, 1'b0, 1'b0});
    add_row(FN_SUB, 32'sh8000_0000, 32'sd1, 1'b1, '{32'sh7FFF_FFFF, 1'b0, 1'b0});
    add_row(FN_MUL, 32'sh100, 32'sh100, 1'b1, '{32'sh100, 1'b0, 1'b0});
    add_row(FN_MUL, 32'sh8000_0000, 32'sh8000_0000);
    add_row(FN_MUL, -32'sd1, 32'sd1, 1'b1, '{-32'sd1, 1'b0, 1'b0});
    add_row(FN_DIV, 32'sh100, 32'sd0, 1'b1, '{32'sd0, 1'b0, 1'b1});
    add_row(FN_DIV, 32'sh8000_0000, -32'sd1);
    add_row(FN_DIV, -32'sd1, 32'sh7FFF_FFFF);
    add_row(FN_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_row(FN_GT, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, '{32'sd0, 1'b1, 1'b0});
    add_row(FN_LT, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, '{32'sd0, 1'b0, 1'b0});
    add_row(FN_GE, 32'sd5, 32'sd5, 1'b1, '{32'sd0, 1'b1, 1'b0});
    add_row(FN_LE, 32'sd5, 32'sd5, 1'b1, '{32'sd0, 1'b1, 1'b0});
    add_row(FN_EQ, 32'sh8000_0000, 32'sh8000_0000, 1'b1, '{32'sd0, 1'b1, 1'b0});
    add_row(FN_NE, 32'sh8000_0000, 32'sh8000_0000, 1'b1, '{32'sd0, 1'b0, 1'b0});
    add_row(FN_MIN, 32'sd7, 32'sd7);
    add_row(FN_MIN, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_row(FN_MAX, 32'sd7, 32'sd7);
    add_row(FN_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_row(FN_INC, 32'sh7FFF_FFFF, 32'sd3, 1'b1, '{32'sh8000_0000, 1'b0, 1'b0});
    add_row(FN_DEC, 32'sh8000_0000, 32'sd3, 1'b1, '{32'sh7FFF_FFFF, 1'b0, 1'b0});
    add_row(FN_TOINT, -32'sd1, 32'sd0, 1'b1, '{-32'sd1, 1'b0, 1'b0});
    add_row(FN_TOINT, 32'sh8000_0000, -32'sd1);
    add_row(FN_FROMINT, 32'sh7FFF_FFFF, -32'sd1);
    add_row(FN_FROMINT, -32'sd1, 32'sd0);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].fn, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].typed, directed_rows[i].res);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      phase = i / (N_RANDOM / 5);
      case (phase)
        0: begin send_gap_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_gap_pct = 86; pop_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  pop_stall_pct = 86; end
        3: begin send_gap_pct = 18; pop_stall_pct = 18; end
        default: begin send_gap_pct = 0; pop_stall_pct = 0; end
      endcase
      fn = func_t'($urandom_range(15));
      send_beat(fn, rand_operand(),
                (fn == FN_DIV && $urandom_range(15) == 0) ? 32'sd0 : rand_operand(),
                1'b0, '0);
    end
    in_push <= 1'b0;
    pop_stall_pct = 0;

    wait_n = 0;
    while (alu_expected_q.size() != 0 && wait_n < 100 * LATENCY) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (LATENCY) @(posedge clk);

    n_ops = 0;
    foreach (ops_seen[k]) n_ops += ops_seen[k];
    $display("Sent %0d beats over %0d of 16 functions, received %0d (%0d divide-by-zero)",
             n_sent, n_ops, n_got, n_dz);
    $display("Flow phases: free, sparse sender, stalled receiver, both idling");
    if (n_fail == 0 && alu_expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (alu_expected_q.size() != 0)
        $display("%0t: %0d expected beats never arrived", $time, alu_expected_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
src/fpa_pkg.sv
src/fpa_front.sv
src/fpa_back.sv
src/fixed_point_alu_q24_8_top.sv
tb/sv/tb_fixed_point_alu_q24_8_top.sv
